// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority ready queue: sizes,
// operation and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH   = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_W    = 8;
	localparam int PRI_W   = 8;
	localparam int ENTRY_W = ID_W + PRI_W;
	localparam int COUNT_W = 6;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_POP,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic start_insert;
		logic start_remove;
		logic refuse_full;
		logic refuse_empty;
		logic shift;
		logic place;
		logic pop;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic shift_more;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: accepts one transaction at a time and sequences the insert
// walk, the pop read and the result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          mode,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);

	spq_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (in_valid) begin
					if (mode == spq_pkg::MODE_INSERT) begin
						state_nxt = sts.full ? spq_pkg::S_RESULT : spq_pkg::S_SHIFT;
					end else begin
						state_nxt = sts.empty ? spq_pkg::S_RESULT : spq_pkg::S_POP;
					end
				end
			end
			spq_pkg::S_SHIFT: begin
				if (!sts.shift_more) begin
					state_nxt = spq_pkg::S_RESULT;
				end
			end
			spq_pkg::S_POP: begin
				state_nxt = spq_pkg::S_RESULT;
			end
			spq_pkg::S_RESULT: begin
				if (sts.out_free) begin
					state_nxt = spq_pkg::S_IDLE;
				end
			end
			default: state_nxt = spq_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != spq_pkg::S_IDLE);
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (in_valid) begin
					if (mode == spq_pkg::MODE_INSERT) begin
						cmd.refuse_full  = sts.full;
						cmd.start_insert = !sts.full;
					end else begin
						cmd.refuse_empty = sts.empty;
						cmd.start_remove = !sts.empty;
					end
				end
			end
			spq_pkg::S_SHIFT: begin
				cmd.shift = sts.shift_more;
				cmd.place = !sts.shift_more;
			end
			spq_pkg::S_POP: begin
				cmd.pop = 1'b1;
			end
			spq_pkg::S_RESULT: begin
				cmd.load_out = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: entry store, occupancy, insert walk pointer, pending result and
// output register.
// ----------------------------------------------------------------------------
module spq_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spq_pkg::cmd_t              cmd,
	output spq_pkg::sts_t              sts,
	input  logic [spq_pkg::ID_W-1:0]   process_id,
	input  logic [spq_pkg::PRI_W-1:0]  priority_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [spq_pkg::ID_W-1:0]   removed_id,
	output logic [spq_pkg::PRI_W-1:0]  removed_priority,
	output logic                       removed_valid,
	output logic [1:0]                 status,
	output logic [spq_pkg::COUNT_W-1:0] entry_count
);

	logic [spq_pkg::CNT_W-1:0]   occ_q;
	logic [spq_pkg::ADDR_W-1:0]  pos_q;
	logic [spq_pkg::ID_W-1:0]    id_q;
	logic [spq_pkg::PRI_W-1:0]   pri_q;

	logic [spq_pkg::ID_W-1:0]    res_id_q;
	logic [spq_pkg::PRI_W-1:0]   res_pri_q;
	logic                        res_valid_q;
	spq_pkg::status_t            res_status_q;

	logic                        out_valid_q;
	logic [spq_pkg::ID_W-1:0]    out_id_q;
	logic [spq_pkg::PRI_W-1:0]   out_pri_q;
	logic                        out_rvalid_q;
	spq_pkg::status_t            out_status_q;
	logic [spq_pkg::COUNT_W-1:0] out_count_q;

	logic                         we;
	logic [spq_pkg::ADDR_W-1:0]   raddr;
	logic [spq_pkg::ENTRY_W-1:0]  wdata;
	logic [spq_pkg::ENTRY_W-1:0]  rdata;
	logic [spq_pkg::ADDR_W-1:0]   occ_top;
	logic [spq_pkg::PRI_W-1:0]    rd_pri;

	assign occ_top = spq_pkg::ADDR_W'(occ_q - spq_pkg::CNT_W'(1));
	assign rd_pri  = rdata[spq_pkg::PRI_W-1:0];

	// status back to the controller
	assign sts.full       = (occ_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
	assign sts.empty      = (occ_q == '0);
	assign sts.shift_more = (pos_q != '0) && (rd_pri > pri_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// store ports: read always targets the slot just below the next position
	always_comb begin
		we    = cmd.shift || cmd.place;
		wdata = cmd.shift ? rdata : {id_q, pri_q};
		if (cmd.start_insert || cmd.start_remove) begin
			raddr = occ_top;
		end else begin
			raddr = pos_q - spq_pkg::ADDR_W'(2);
		end
	end

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (spq_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (pos_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.start_remove) begin
			occ_q <= occ_q - spq_pkg::CNT_W'(1);
		end else if (cmd.place) begin
			occ_q <= occ_q + spq_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_insert) begin
			pos_q <= spq_pkg::ADDR_W'(occ_q);
			id_q  <= process_id;
			pri_q <= priority_req;
		end else if (cmd.shift) begin
			pos_q <= pos_q - spq_pkg::ADDR_W'(1);
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.refuse_full || cmd.refuse_empty || cmd.place) begin
			res_id_q     <= '0;
			res_pri_q    <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= cmd.refuse_full  ? spq_pkg::ST_FULL  :
			                cmd.refuse_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
		end else if (cmd.pop) begin
			res_id_q     <= rdata[spq_pkg::ENTRY_W-1:spq_pkg::PRI_W];
			res_pri_q    <= rd_pri;
			res_valid_q  <= 1'b1;
			res_status_q <= spq_pkg::ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_id_q     <= res_id_q;
			out_pri_q    <= res_pri_q;
			out_rvalid_q <= res_valid_q;
			out_status_q <= res_status_q;
			out_count_q  <= spq_pkg::COUNT_W'(occ_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign removed_id       = out_id_q;
	assign removed_priority = out_pri_q;
	assign removed_valid    = out_rvalid_q;
	assign status           = out_status_q;
	assign entry_count      = out_count_q;

endmodule

// ===== sv/sorted_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_ready_queue
// Ready queue of (process id, priority) entries kept in ascending priority
// order in a single-port-write RAM; remove pops the highest priority entry.
// ----------------------------------------------------------------------------
// Sequencing: an accepted insert walks in S_SHIFT, one RAM entry per cycle,
//   past the k entries of strictly greater priority (0..DEPTH-1), then places
//   the new entry; a remove passes through S_POP; a refused insert (full) or
//   remove (empty) goes straight to S_RESULT, which loads the output register
//   once it is free. Throughput: one transaction in flight; the next can be
//   accepted in the cycle after the result is loaded.
// Reset: arst_n clears occupancy, controller state and the output valid; the
//   entry RAM is not cleared, as only data below the occupancy is ever used.
// ----------------------------------------------------------------------------
module sorted_priority_ready_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	// input transaction channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [spq_pkg::ID_W-1:0]     process_id,
	input  logic [spq_pkg::PRI_W-1:0]    priority_req,
	// result transaction channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [spq_pkg::ID_W-1:0]     removed_id,
	output logic [spq_pkg::PRI_W-1:0]    removed_priority,
	output logic                         removed_valid,
	output logic [1:0]                   status,
	output logic [spq_pkg::COUNT_W-1:0]  entry_count
);

	// Command and status bundles between controller and datapath.
	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	// Controller: hold off new transactions until the current result has been
	// loaded into the output register, walk the insert one slot per cycle.
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: the sorted store, occupancy, walk pointer and the output
	// register that parts the result channel from the controller.
	spq_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.process_id       (process_id),
		.priority_req     (priority_req),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.removed_id       (removed_id),
		.removed_priority (removed_priority),
		.removed_valid    (removed_valid),
		.status           (status),
		.entry_count      (entry_count)
	);

	// An accepted transaction blocks the input until its result is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction was in flight");

	// A popped entry is only ever reported with an ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && removed_valid) |-> (status == spq_pkg::ST_OK))
		else $error("removed entry reported with a refusal status");

	// A refused remove means the queue held nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::ST_EMPTY) |->
		(entry_count == '0 && !removed_valid))
		else $error("empty refusal with nonzero count or a removed entry");

	// A refused insert means the queue was at capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::ST_FULL) |->
		(entry_count == spq_pkg::COUNT_W'(spq_pkg::DEPTH)))
		else $error("full refusal with count below capacity");

endmodule
